/* rtl/core/path_expression_tokenizer_defines.svh */
// Assertion macros for the tokenizer checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PATH_EXPRESSION_TOKENIZER_DEFINES_SVH
`define PATH_EXPRESSION_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PET_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/pet_pkg.sv */
package pet_pkg;

	// Result kinds
	localparam logic [1:0] K_CHAR     = 2'd0;
	localparam logic [1:0] K_NAME_END = 2'd1;
	localparam logic [1:0] K_INDEX    = 2'd2;
	localparam logic [1:0] K_END      = 2'd3;

	// Path end status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_BACKSLASH = 3'd2;
	localparam logic [2:0] ST_DOLLAR    = 3'd3;
	localparam logic [2:0] ST_DELIM     = 3'd4;
	localparam logic [2:0] ST_BRACKET   = 3'd5;
	localparam logic [2:0] ST_INDEX     = 3'd6;
	localparam logic [2:0] ST_COMPONENT = 3'd7;

	// Syntax bytes
	localparam logic [7:0] CH_DOLLAR   = 8'h24;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;

	// Index magnitude limits
	localparam logic [31:0] INDEX_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] INDEX_NEG_MAG = 32'h8000_0000;

	// Mask bits of a bundle, in emission order
	localparam int unsigned B_STEP = 0;
	localparam int unsigned B_FIN  = 1;
	localparam int unsigned B_END  = 2;

	typedef enum logic [2:0] {
		PH_START,
		PH_DOLLAR,
		PH_NAME,
		PH_INDEX,
		PH_AFTER_INDEX
	} phase_t;

	// Up to three results caused by one input item:
	// step result, closing name end, path end.
	typedef struct packed {
		logic [2:0]  mask;
		logic [1:0]  step_kind;
		logic [31:0] data;
		logic [2:0]  status;
	} pet_bundle_t;

endpackage

/* rtl/core/pet_front.sv */
module pet_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               take,
	input  logic [7:0]         path_byte,
	input  logic               last_byte,
	input  logic               empty_path,
	output logic               bundle_valid,
	output pet_pkg::pet_bundle_t bundle
);
	import pet_pkg::*;

	logic        at_start_q;
	phase_t      phase_q, phase_d;
	logic        esc_q, esc_d;
	logic        ne_q, ne_d;
	logic [31:0] mag_q, mag_d;
	logic        neg_q, neg_d;
	logic        dig_q, dig_d;
	logic        ovf_q, ovf_d;
	logic [2:0]  err_q, err_d;

	logic        step_vld, fin, endv, idx_ok, is_digit;
	logic [1:0]  step_kind;
	logic [31:0] data;
	logic [2:0]  st;
	logic [34:0] mag_next;

	assign is_digit = (path_byte >= CH_ZERO) && (path_byte <= CH_NINE);
	// times ten plus digit, as shift and add
	assign mag_next = {mag_q, 3'b000} + {2'b00, mag_q, 1'b0} + {31'd0, path_byte[3:0]};
	assign idx_ok = dig_q && !ovf_q &&
		(neg_q ? (mag_q <= INDEX_NEG_MAG) : (mag_q <= INDEX_POS_MAX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			phase_q    <= PH_START;
			esc_q      <= 1'b0;
			ne_q       <= 1'b0;
			mag_q      <= '0;
			neg_q      <= 1'b0;
			dig_q      <= 1'b0;
			ovf_q      <= 1'b0;
			err_q      <= ST_OK;
		end else begin
			if (cfg_we) at_start_q <= cfg_wdata;
			if (take) begin
				phase_q <= phase_d;
				esc_q   <= esc_d;
				ne_q    <= ne_d;
				mag_q   <= mag_d;
				neg_q   <= neg_d;
				dig_q   <= dig_d;
				ovf_q   <= ovf_d;
				err_q   <= err_d;
			end
		end
	end

	always_comb begin
		phase_d   = phase_q;
		esc_d     = esc_q;
		ne_d      = ne_q;
		mag_d     = mag_q;
		neg_d     = neg_q;
		dig_d     = dig_q;
		ovf_d     = ovf_q;
		err_d     = err_q;
		step_vld  = 1'b0;
		step_kind = K_CHAR;
		data      = '0;
		fin       = 1'b0;
		endv      = 1'b0;
		st        = ST_OK;

		if (empty_path) begin
			endv = 1'b1;
			st   = ST_EMPTY;
		end else begin
			if (err_q == ST_OK) begin
				case (phase_q)
					PH_DOLLAR, PH_AFTER_INDEX: begin
						if (path_byte == CH_DOT) begin
							phase_d = PH_NAME;
							ne_d    = 1'b0;
							esc_d   = 1'b0;
						end else if (path_byte == CH_LBRACKET) begin
							phase_d = PH_INDEX;
							mag_d   = '0;
							neg_d   = 1'b0;
							dig_d   = 1'b0;
							ovf_d   = 1'b0;
						end else begin
							err_d = (phase_q == PH_DOLLAR) ? ST_DELIM : ST_COMPONENT;
						end
					end
					PH_NAME: begin
						if (esc_q) begin
							esc_d    = 1'b0;
							ne_d     = 1'b1;
							step_vld = 1'b1;
							data     = {24'd0, path_byte};
						end else if (path_byte == CH_BSLASH) begin
							esc_d = 1'b1;
						end else if (path_byte == CH_DOT || path_byte == CH_LBRACKET) begin
							if (ne_q) begin
								step_vld  = 1'b1;
								step_kind = K_NAME_END;
							end
							if (path_byte == CH_DOT) begin
								phase_d = PH_NAME;
								ne_d    = 1'b0;
								esc_d   = 1'b0;
							end else begin
								phase_d = PH_INDEX;
								mag_d   = '0;
								neg_d   = 1'b0;
								dig_d   = 1'b0;
								ovf_d   = 1'b0;
							end
						end else begin
							ne_d     = 1'b1;
							step_vld = 1'b1;
							data     = {24'd0, path_byte};
						end
					end
					PH_INDEX: begin
						if (path_byte == CH_RBRACKET) begin
							if (idx_ok) begin
								step_vld  = 1'b1;
								step_kind = K_INDEX;
								data      = neg_q ? (32'd0 - mag_q) : mag_q;
								phase_d   = PH_AFTER_INDEX;
							end else begin
								err_d = ST_INDEX;
							end
						end else if (path_byte == CH_MINUS && !neg_q && !dig_q && !ovf_q) begin
							neg_d = 1'b1;
						end else if (is_digit) begin
							if (!ovf_q) begin
								if (mag_next > {3'b000, INDEX_NEG_MAG}) ovf_d = 1'b1;
								else mag_d = mag_next[31:0];
							end
							dig_d = 1'b1;
						end else begin
							ovf_d = 1'b1;
						end
					end
					default: begin
						// start of path
						if (path_byte == CH_DOLLAR) begin
							if (at_start_q) phase_d = PH_DOLLAR;
							else err_d = ST_DOLLAR;
						end else if (path_byte == CH_LBRACKET) begin
							phase_d = PH_INDEX;
							mag_d   = '0;
							neg_d   = 1'b0;
							dig_d   = 1'b0;
							ovf_d   = 1'b0;
						end else begin
							phase_d = PH_NAME;
							ne_d    = 1'b0;
							esc_d   = 1'b0;
							if (path_byte == CH_BSLASH) begin
								esc_d = 1'b1;
							end else if (path_byte != CH_DOT) begin
								ne_d     = 1'b1;
								step_vld = 1'b1;
								data     = {24'd0, path_byte};
							end
						end
					end
				endcase
			end
			if (last_byte) begin
				endv = 1'b1;
				if (path_byte == CH_BSLASH) st = ST_BACKSLASH;
				else if (err_d != ST_OK) st = err_d;
				else if (phase_d == PH_INDEX) st = ST_BRACKET;
				else st = ST_OK;
				fin = (st == ST_OK) && (phase_d == PH_NAME) && ne_d;
			end
		end

		// path ends: drop all path state
		if (endv) begin
			phase_d = PH_START;
			esc_d   = 1'b0;
			ne_d    = 1'b0;
			mag_d   = '0;
			neg_d   = 1'b0;
			dig_d   = 1'b0;
			ovf_d   = 1'b0;
			err_d   = ST_OK;
		end
	end

	assign bundle.mask      = {endv, fin, step_vld};
	assign bundle.step_kind = step_kind;
	assign bundle.data      = data;
	assign bundle.status    = st;
	assign bundle_valid     = take && (step_vld || fin || endv);

endmodule

/* rtl/core/pet_queue.sv */
module pet_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  pet_pkg::pet_bundle_t wr_data,
	output logic                 full,
	input  logic                 rd_en,
	output pet_pkg::pet_bundle_t rd_data,
	output logic                 not_empty
);
	import pet_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	pet_bundle_t   slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) slots_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* rtl/core/pet_back.sv */
module pet_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  pet_pkg::pet_bundle_t head,
	output logic                 head_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [1:0]           kind,
	output logic [7:0]           name_char,
	output logic signed [31:0]   index_value,
	output logic [2:0]           status,
	output logic                 end_of_run
);
	import pet_pkg::*;

	logic [2:0]  done_q;
	logic [2:0]  rem, sel;
	logic        last_of, load, out_valid_q;
	logic [1:0]  kind_d;
	logic [7:0]  char_d;
	logic [31:0] idx_d;
	logic [2:0]  st_d;

	assign rem     = head.mask & ~done_q;
	assign sel     = rem & (~rem + 3'd1);
	assign last_of = ((rem & ~sel) == 3'd0);
	assign load    = head_valid && (!out_valid_q || pop);
	assign head_pop = load && last_of;
	assign empty   = !out_valid_q;

	always_comb begin
		kind_d = K_END;
		char_d = '0;
		idx_d  = '0;
		st_d   = ST_OK;
		if (sel[B_STEP]) begin
			kind_d = head.step_kind;
			if (head.step_kind == K_CHAR) char_d = head.data[7:0];
			if (head.step_kind == K_INDEX) idx_d = head.data;
		end else if (sel[B_FIN]) begin
			kind_d = K_NAME_END;
		end else begin
			st_d = head.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				done_q      <= last_of ? 3'd0 : (done_q | sel);
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind        <= kind_d;
			name_char   <= char_d;
			index_value <= idx_d;
			status      <= st_d;
			end_of_run  <= last_of;
		end
	end

endmodule

/* rtl/core/path_expression_tokenizer.sv */
// Path expression tokenizer. Feed a path such as $.a[3].b one byte per item with push/full;
// mark the final byte with last_byte, or send empty_path for a zero-length path. Results come
// out on the pop/empty side in order: each unescaped name byte (kind 0), a name end mark
// (kind 1), each bracketed index as a signed 32-bit value (kind 2), and a path end with its
// status (kind 3); end_of_run flags the last result caused by a given byte. A byte is taken
// every cycle while the result queue (QUEUE_DEPTH entries, each holding all results of one
// byte) has room; each result passes through the queue and then the output register. One
// byte gives zero to three results; the output register hands out one result per cycle
// while pop is held. A path whose bytes average at most one result each streams at one
// byte per cycle. at_start resets to 1; the user writes it through at_start_we and
// at_start_wdata only while the block is idle, which the block does not enforce.
module path_expression_tokenizer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               at_start_we,
	input  logic               at_start_wdata,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         path_byte,
	input  logic               last_byte,
	input  logic               empty_path,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         kind,
	output logic [7:0]         name_char,
	output logic signed [31:0] index_value,
	output logic [2:0]         status,
	output logic               end_of_run
);
	import pet_pkg::*;

	logic        take;
	logic        bundle_valid;
	pet_bundle_t bundle;
	logic        head_valid;
	pet_bundle_t head;
	logic        head_pop;

	// Take a byte whenever the queue can hold its results.
	assign take = push && !full;

	// Front: classify each byte and advance the path state machine.
	pet_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (at_start_we),
		.cfg_wdata    (at_start_wdata),
		.take         (take),
		.path_byte    (path_byte),
		.last_byte    (last_byte),
		.empty_path   (empty_path),
		.bundle_valid (bundle_valid),
		.bundle       (bundle)
	);

	// Queue: hold result bundles so either side can stall alone.
	pet_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (bundle_valid),
		.wr_data   (bundle),
		.full      (full),
		.rd_en     (head_pop),
		.rd_data   (head),
		.not_empty (head_valid)
	);

	// Back: split each bundle into single results behind an output register.
	pet_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.head_pop    (head_pop),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.name_char   (name_char),
		.index_value (index_value),
		.status      (status),
		.end_of_run  (end_of_run)
	);

endmodule

/* rtl/core/pet_checker.sv */
`include "path_expression_tokenizer_defines.svh"

module pet_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [1:0]         kind,
	input logic [7:0]         name_char,
	input logic signed [31:0] index_value,
	input logic [2:0]         status,
	input logic               end_of_run
);
	import pet_pkg::*;

	// a waiting result holds until taken
	`PET_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(kind) && $stable(status), "result changed while stalled")
	// a path end is always the last result of its byte
	`PET_ASSERT_NOW(a_end_last, !empty && kind == K_END, end_of_run, "path end not last of run")
	`PET_ASSERT_NOW(a_char_zero, !empty && kind != K_CHAR, name_char == 8'd0, "name_char set on non-char result")
	`PET_ASSERT_NOW(a_status_zero, !empty && kind != K_END, status == ST_OK, "status set before path end")
	`PET_ASSERT_NOW(a_index_zero, !empty && kind != K_INDEX, index_value == 32'sd0, "index set on non-index result")

endmodule

bind path_expression_tokenizer pet_checker u_pet_checker (.*);

/* tb/tb_top.sv */
module tb_top;
	import pet_pkg::*;

	// One result of the tokenizer as seen on the pop side.
	typedef struct {
		logic [1:0]         kind;
		logic [7:0]         ch;
		logic signed [31:0] idx;
		logic [2:0]         st;
		logic               eor;
	} token_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               at_start_we = 1'b0;
	logic               at_start_wdata = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [7:0]         path_byte = 8'h00;
	logic               last_byte = 1'b0;
	logic               empty_path = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic [1:0]         kind;
	logic [7:0]         name_char;
	logic signed [31:0] index_value;
	logic [2:0]         status;
	logic               end_of_run;

	path_expression_tokenizer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.at_start_we    (at_start_we),
		.at_start_wdata (at_start_wdata),
		.push           (push),
		.full           (full),
		.path_byte      (path_byte),
		.last_byte      (last_byte),
		.empty_path     (empty_path),
		.empty          (empty),
		.pop            (pop),
		.kind           (kind),
		.name_char      (name_char),
		.index_value    (index_value),
		.status         (status),
		.end_of_run     (end_of_run)
	);

	// Results predicted for accepted items and not yet popped, oldest first.
	token_t pending_tokens[$];
	token_t step_tokens[$];
	logic [7:0] path_buf[$];

	int mismatch_count = 0;
	int items_sent = 0;
	bit gaps_on = 1'b0;
	int hold_request = 0;

	// Tokenizer state mirror. root_ok tracks the at_start register.
	bit          root_ok = 1'b1;
	phase_t      tok_phase = PH_START;
	bit          esc_pend = 1'b0;
	bit          name_seen = 1'b0;
	logic [31:0] idx_mag = '0;
	bit          idx_neg = 1'b0;
	bit          idx_dig = 1'b0;
	bit          idx_bad = 1'b0;
	logic [2:0]  path_err = ST_OK;

	initial forever #6 clk = ~clk;

	// Generous bound on the whole run; a hang ends here.
	initial begin
		#(12 * 600000);
		$display("TEST FAILED");
		$finish;
	end

	// Append one byte to the path being built.
	function automatic void add_path_byte(input logic [7:0] b);
		path_buf.insert(path_buf.size(), b);
	endfunction

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic void add_token(logic [1:0] k, logic [7:0] c, logic [31:0] v,
		logic [2:0] s);
		token_t t;
		t.kind = k;
		t.ch = c;
		t.idx = v;
		t.st = s;
		t.eor = 1'b0;
		step_tokens.insert(step_tokens.size(), t);
	endfunction

	function automatic void path_restart();
		tok_phase = PH_START;
		esc_pend = 1'b0;
		name_seen = 1'b0;
		idx_mag = '0;
		idx_neg = 1'b0;
		idx_dig = 1'b0;
		idx_bad = 1'b0;
		path_err = ST_OK;
	endfunction

	function automatic void begin_index();
		tok_phase = PH_INDEX;
		idx_mag = '0;
		idx_neg = 1'b0;
		idx_dig = 1'b0;
		idx_bad = 1'b0;
	endfunction

	function automatic void begin_name();
		tok_phase = PH_NAME;
		name_seen = 1'b0;
		esc_pend = 1'b0;
	endfunction

	function automatic void feed_name_byte(logic [7:0] b);
		if (esc_pend) begin
			// escaped byte is literal, even a delimiter
			esc_pend = 1'b0;
			name_seen = 1'b1;
			add_token(K_CHAR, b, '0, ST_OK);
		end else if (b == CH_BSLASH) begin
			esc_pend = 1'b1;
		end else if (b == CH_DOT || b == CH_LBRACKET) begin
			// empty names close silently
			if (name_seen)
				add_token(K_NAME_END, '0, '0, ST_OK);
			if (b == CH_DOT)
				begin_name();
			else
				begin_index();
		end else begin
			name_seen = 1'b1;
			add_token(K_CHAR, b, '0, ST_OK);
		end
	endfunction

	function automatic void feed_index_byte(logic [7:0] b);
		logic [63:0] acc;
		bit ok;
		if (b == CH_RBRACKET) begin
			ok = idx_dig && !idx_bad &&
				(idx_neg ? idx_mag <= INDEX_NEG_MAG : idx_mag <= INDEX_POS_MAX);
			if (ok) begin
				add_token(K_INDEX, '0, idx_neg ? 32'd0 - idx_mag : idx_mag, ST_OK);
				tok_phase = PH_AFTER_INDEX;
			end else begin
				path_err = ST_INDEX;
			end
		end else if (b == CH_MINUS && !idx_neg && !idx_dig && !idx_bad) begin
			idx_neg = 1'b1;
		end else if (b >= CH_ZERO && b <= CH_NINE) begin
			// saturate: anything past 2^31 is out of range for either sign
			if (!idx_bad) begin
				acc = {32'd0, idx_mag} * 64'd10 + {56'd0, b - CH_ZERO};
				if (acc > {32'd0, INDEX_NEG_MAG})
					idx_bad = 1'b1;
				else
					idx_mag = acc[31:0];
			end
			idx_dig = 1'b1;
		end else begin
			idx_bad = 1'b1;
		end
	endfunction

	function automatic void take_path_byte(logic [7:0] b);
		case (tok_phase)
			PH_DOLLAR: begin
				if (b == CH_DOT) begin_name();
				else if (b == CH_LBRACKET) begin_index();
				else path_err = ST_DELIM;
			end
			PH_NAME: feed_name_byte(b);
			PH_INDEX: feed_index_byte(b);
			PH_AFTER_INDEX: begin
				if (b == CH_DOT) begin_name();
				else if (b == CH_LBRACKET) begin_index();
				else path_err = ST_COMPONENT;
			end
			default: begin
				if (b == CH_DOLLAR) begin
					if (root_ok) tok_phase = PH_DOLLAR;
					else path_err = ST_DOLLAR;
				end else if (b == CH_LBRACKET) begin
					begin_index();
				end else if (b == CH_DOT) begin
					begin_name();
				end else begin
					begin_name();
					feed_name_byte(b);
				end
			end
		endcase
	endfunction

	// Work out every result one accepted item causes and queue them.
	function automatic void tokenize_byte(logic [7:0] b, bit last, bit emp);
		logic [2:0] fin;
		step_tokens.delete();
		if (emp) begin
			add_token(K_END, '0, '0, ST_EMPTY);
			path_restart();
		end else begin
			if (path_err == ST_OK)
				take_path_byte(b);
			if (last) begin
				// trailing backslash wins over any earlier error
				if (b == CH_BSLASH) fin = ST_BACKSLASH;
				else if (path_err != ST_OK) fin = path_err;
				else if (tok_phase == PH_INDEX) fin = ST_BRACKET;
				else fin = ST_OK;
				if (fin == ST_OK && tok_phase == PH_NAME && name_seen)
					add_token(K_NAME_END, '0, '0, ST_OK);
				add_token(K_END, '0, '0, fin);
				path_restart();
			end
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].eor = 1'b1;
		foreach (step_tokens[i])
			pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
	endfunction

	// ------------------------------------------------------------------
	// Result side: pop driver and checker
	// ------------------------------------------------------------------
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				if (gaps_on) begin
					r = $urandom_range(0, 99);
					if (r < 20) stall_left = $urandom_range(1, 3);
					else if (r < 23) stall_left = $urandom_range(15, 40);
				end
			end
		end
	end

	function automatic void note_failure(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endfunction

	always @(posedge clk) begin
		token_t want;
		if (arst_n && pop && !empty) begin
			if (pending_tokens.size() == 0) begin
				note_failure($sformatf("unexpected result: kind=%0d char=%02h index=%0d status=%0d eor=%0b",
					kind, name_char, index_value, status, end_of_run));
			end else begin
				want = pending_tokens.pop_front();
				if (kind !== want.kind || name_char !== want.ch || index_value !== want.idx ||
					status !== want.st || end_of_run !== want.eor)
					note_failure($sformatf({"result mismatch: expected kind=%0d char=%02h index=%0d ",
						"status=%0d eor=%0b, got kind=%0d char=%02h index=%0d status=%0d eor=%0b"},
						want.kind, want.ch, want.idx, want.st, want.eor,
						kind, name_char, index_value, status, end_of_run));
			end
		end
	end

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one item and hold it until taken. push stays high when no gap follows.
	task automatic send_item(input logic [7:0] b, input bit last, input bit emp);
		int gap;
		push <= 1'b1;
		path_byte <= b;
		last_byte <= last;
		empty_path <= emp;
		do @(posedge clk); while (full);
		tokenize_byte(b, last, emp);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_path_buf();
		foreach (path_buf[i])
			send_item(path_buf[i], i == path_buf.size() - 1, 1'b0);
	endtask

	task automatic send_text(input string s);
		path_buf.delete();
		foreach (s[i])
			add_path_byte(s[i]);
		send_path_buf();
	endtask

	// Drop push and wait until the block has handed out everything.
	task automatic wait_idle();
		push <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		// items that cause no result may still be in flight
		repeat (6) @(posedge clk);
	endtask

	task automatic set_root_mode(input bit v);
		wait_idle();
		at_start_we <= 1'b1;
		at_start_wdata <= v;
		@(posedge clk);
		root_ok = v;
		at_start_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Random path generation
	// ------------------------------------------------------------------
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == CH_DOT || b == CH_LBRACKET || b == CH_BSLASH);
		return b;
	endfunction

	function automatic logic [7:0] noise_byte();
		logic [7:0] syntax[8];
		syntax = '{CH_DOLLAR, CH_DOT, CH_LBRACKET, CH_RBRACKET, CH_BSLASH, CH_MINUS,
			CH_ZERO, CH_NINE};
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 255));
			1: return syntax[$urandom_range(0, 7)];
			2: return CH_ZERO + 8'($urandom_range(0, 9));
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic string index_text();
		string odd[7];
		longint v;
		odd = '{"", "-", "007", "-0", "99999999999", "1-2", "--5"};
		case ($urandom_range(0, 8))
			0: v = $urandom_range(0, 9);
			1: v = $urandom_range(0, 999);
			2: v = 64'sd2147483647;
			3: v = -64'sd2147483648;
			4: v = 64'sd2147483648;
			5: v = -64'sd2147483649;
			6: v = longint'($signed($urandom()));
			7: v = -longint'($urandom_range(1, 99999));
			default: return odd[$urandom_range(0, 6)];
		endcase
		return $sformatf("%0d", v);
	endfunction

	function automatic void append_name();
		int r;
		repeat ($urandom_range(0, 5)) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				add_path_byte(CH_BSLASH);
				add_path_byte(8'($urandom_range(0, 255)));
			end else if (r < 25) begin
				add_path_byte(plain_byte());
			end else begin
				add_path_byte(8'h61 + 8'($urandom_range(0, 25)));
			end
		end
	endfunction

	function automatic void append_index();
		string s;
		s = index_text();
		add_path_byte(CH_LBRACKET);
		foreach (s[i])
			add_path_byte(s[i]);
		add_path_byte(CH_RBRACKET);
	endfunction

	// Path of names and indexes with random content, then an occasional defect.
	function automatic void build_path();
		bit rooted;
		int comps;
		rooted = ($urandom_range(0, 3) == 0);
		path_buf.delete();
		if (rooted)
			add_path_byte(CH_DOLLAR);
		comps = $urandom_range(1, 4);
		for (int c = 0; c < comps; c++) begin
			if ($urandom_range(0, 9) < 7) begin
				if (c > 0 || rooted || $urandom_range(0, 1))
					add_path_byte(CH_DOT);
				append_name();
			end else begin
				append_index();
			end
		end
		if (path_buf.size() == 0)
			add_path_byte(8'h61 + 8'($urandom_range(0, 25)));
		if ($urandom_range(0, 99) < 30) begin
			case ($urandom_range(0, 3))
				0: path_buf[$urandom_range(0, path_buf.size() - 1)] = noise_byte();
				1: if (path_buf.size() > 1) void'(path_buf.pop_back());
				2: add_path_byte(CH_BSLASH);
				default: path_buf.insert($urandom_range(0, path_buf.size()), noise_byte());
			endcase
		end
	endfunction

	function automatic void build_noise();
		path_buf.delete();
		repeat ($urandom_range(1, 6))
			add_path_byte(noise_byte());
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed_cases();
		gaps_on = 1'b0;
		set_root_mode(1'b1);
		send_text("$");              // lone root is fine
		send_text("$x");             // root not followed by a delimiter
		send_text("[7]x");           // index, then junk where a delimiter belongs
		send_text(".\\[\\");         // escaped bracket, then trailing backslash
		send_text("[-]");            // sign with no digits
		send_text("[");              // path ends inside brackets
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h61, 1'b0, 1'b0);
		send_item(8'hA5, 1'b1, 1'b1); // empty path cuts a path in progress
	endtask

	task automatic test_root_disabled();
		set_root_mode(1'b0);
		send_text("$.a");            // root marker not allowed here
		send_text("[0].b");
	endtask

	task automatic test_random_paths(input bit root, input int budget);
		int stop_at;
		int r;
		int cut;
		set_root_mode(root);
		gaps_on = 1'b1;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
			end else begin
				if (r < 15) build_noise();
				else build_path();
				if ($urandom_range(0, 99) < 6) begin
					// abandon the path part way with an empty-path item
					cut = $urandom_range(0, path_buf.size() - 1);
					for (int i = 0; i < cut; i++)
						send_item(path_buf[i], 1'b0, 1'b0);
					send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
				end else begin
					send_path_buf();
				end
			end
		end
	endtask

	// Hold the pop side off while names stream in back to back.
	task automatic test_output_backpressure();
		set_root_mode(1'b1);
		gaps_on = 1'b0;
		hold_request = 150;
		path_buf.delete();
		for (int i = 0; i < 40; i++)
			add_path_byte(8'h61 + 8'(i % 26));
		send_path_buf();
		send_text("[-2147483648][2147483647]");
	endtask

	// Sender waits for a full drain before going on.
	task automatic test_drain_pause();
		gaps_on = 1'b1;
		send_text("x[12].y");
		wait_idle();
		send_text("$[3].z");
		wait_idle();
		send_text("q.r");
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_root_disabled();
		test_random_paths(1'b1, 130);
		test_random_paths(1'b0, 110);
		test_output_backpressure();
		test_random_paths(1'b1, 110);
		test_drain_pause();

		wait_idle();
		repeat (20) @(posedge clk);
		if (pending_tokens.size() != 0)
			note_failure($sformatf("%0d expected results never arrived", pending_tokens.size()));
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/pet_pkg.sv
rtl/core/pet_front.sv
rtl/core/pet_queue.sv
rtl/core/pet_back.sv
rtl/core/path_expression_tokenizer.sv
rtl/core/pet_checker.sv
tb/tb_top.sv
